### rtl/fcdc_pkg.sv
// ---------------------------------------------------------------------------
// fcdc_pkg: shared constants and Gear table for the chunk boundary core
// Register indexes, reset values, cut cause codes and the fixed Gear ROM.
// ---------------------------------------------------------------------------
package fcdc_pkg;

    localparam int SIZE_W  = 21;
    localparam int MASK_W  = 48;
    localparam int END_W   = 48;
    localparam int CAUSE_W = 2;
    localparam int ADDR_W  = 3;

    // Register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_MIN_SIZE     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_AVG_SIZE     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_SIZE     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_STRICT_MASK  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RELAXED_MASK = 3'd4;

    localparam logic [SIZE_W-1:0] RST_MIN_SIZE     = 21'd2048;
    localparam logic [SIZE_W-1:0] RST_AVG_SIZE     = 21'd8192;
    localparam logic [SIZE_W-1:0] RST_MAX_SIZE     = 21'd65536;
    localparam logic [MASK_W-1:0] RST_STRICT_MASK  = 48'hd9f0_0353_0000;
    localparam logic [MASK_W-1:0] RST_RELAXED_MASK = 48'hd900_0353_0000;

    // Cut causes
    localparam logic [CAUSE_W-1:0] CAUSE_MATCH = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MAX   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_EOD   = 2'd2;

    // Gear table: xorshift64 sequence, one step per entry
    localparam logic [63:0] GEAR_SEED  = 64'h1234_5678_9abc_def0;
    localparam int          GEAR_SH_A  = 13;
    localparam int          GEAR_SH_B  = 7;
    localparam int          GEAR_SH_C  = 17;
    localparam int          GEAR_DEPTH = 256;

    typedef logic [63:0] gear_tab_t [GEAR_DEPTH];

    function automatic gear_tab_t gear_fill();
        gear_tab_t   tab;
        logic [63:0] x;
        x = GEAR_SEED;
        for (int k = 0; k < GEAR_DEPTH; k++) begin
            x = x ^ (x << GEAR_SH_A);
            x = x ^ (x >> GEAR_SH_B);
            x = x ^ (x << GEAR_SH_C);
            tab[k] = x;
        end
        return tab;
    endfunction

    localparam gear_tab_t GEAR_ROM = gear_fill();

endpackage

### rtl/fastcdc_chunk_boundary_core.sv
// ---------------------------------------------------------------------------
// fastcdc_chunk_boundary_core: content-defined chunk boundary detector
// Gear fingerprint with cut-point skipping and two-mask normalized chunking;
// one data byte per beat in, one boundary record per finished chunk out.
// ---------------------------------------------------------------------------
//  channel  | ports                                        | dir
//  ---------+----------------------------------------------+-----
//  s_       | s_valid s_ready s_byte_value s_end_of_data   | in
//  m_       | m_valid m_ready m_chunk_end m_chunk_length   | out
//           | m_cut_cause                                  |
//  cfg_     | cfg_wr_en cfg_addr cfg_wdata                 | in
//
// One byte per cycle sustained while m_ready stays high. A byte is held in the
// input register; the Gear ROM read, the fingerprint add and the mask test run
// combinationally on it; when the output register is free the boundary record
// lands there and drives m_valid. A held output record stalls the input register,
// and s_ready drops once that register is full too; reset is synchronous and
// needs no clearing pass.
module fastcdc_chunk_boundary_core
    import fcdc_pkg::*;
#(
    parameter int MAX_CHUNK_BYTES = 1048576,
    parameter int OFFSET_BITS     = 48,
    parameter int WINDOW_BITS     = 48
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [MASK_W-1:0]  cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_value,
    input  logic               s_end_of_data,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [END_W-1:0]   m_chunk_end,
    output logic [SIZE_W-1:0]  m_chunk_length,
    output logic [CAUSE_W-1:0] m_cut_cause
);

    localparam int CNT_W = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_CHUNK_BYTES);

    // configuration
    logic [SIZE_W-1:0] min_size_reg, avg_size_reg, max_size_reg;
    logic [MASK_W-1:0] strict_mask_reg, relaxed_mask_reg;

    // input register
    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              in_eod_reg;

    // chunk state
    logic [WINDOW_BITS-1:0] fp_reg, fp_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    // output register
    logic               out_vld_reg;
    logic [END_W-1:0]   out_end_reg;
    logic [SIZE_W-1:0]  out_len_reg;
    logic [CAUSE_W-1:0] out_cause_reg;

    logic                   advance;
    logic [CMP_W-1:0]       len, top, min_ext, avg_ext;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [63:0]            off64, gear_word, fp64, mask64;
    logic [WINDOW_BITS-1:0] fp_upd;
    logic [MASK_W-1:0]      sel_mask;
    logic                   cut_max, in_test, hit, cut;
    logic [CAUSE_W-1:0]     cause;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    assign m_valid        = out_vld_reg;
    assign m_chunk_end    = out_end_reg;
    assign m_chunk_length = out_len_reg;
    assign m_cut_cause    = out_cause_reg;

    always_comb begin
        len     = CMP_W'(count_reg) + CMP_W'(1);
        min_ext = CMP_W'(min_size_reg);
        avg_ext = CMP_W'(avg_size_reg);
        top     = (CMP_W'(max_size_reg) < MAX_C) ? CMP_W'(max_size_reg) : MAX_C;

        // saturating byte offset
        off_inc = (offset_reg != '1) ? offset_reg + OFFSET_BITS'(1) : offset_reg;
        off64   = 64'(off_inc);

        gear_word = GEAR_ROM[in_byte_reg];
        fp_upd    = (fp_reg << 1) + WINDOW_BITS'(gear_word);
        sel_mask  = (len < avg_ext) ? strict_mask_reg : relaxed_mask_reg;
        fp64      = 64'(fp_upd);
        mask64    = 64'(sel_mask);
        hit       = ((fp64 & mask64) == 64'd0);

        cut_max = (len >= top);
        in_test = (len >= min_ext);

        // end of data wins over everything, then forced maximum, then match
        if (in_eod_reg) begin
            cut   = 1'b1;
            cause = CAUSE_EOD;
        end else if (cut_max) begin
            cut   = 1'b1;
            cause = CAUSE_MAX;
        end else begin
            cut   = in_test && hit;
            cause = CAUSE_MATCH;
        end

        fp_next     = fp_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        if (advance) begin
            offset_next = in_eod_reg ? '0 : off_inc;
            if (cut) begin
                fp_next    = '0;
                count_next = '0;
            end else begin
                count_next = len[CNT_W-1:0];
                if (in_test) begin
                    fp_next = fp_upd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg     <= RST_MIN_SIZE;
            avg_size_reg     <= RST_AVG_SIZE;
            max_size_reg     <= RST_MAX_SIZE;
            strict_mask_reg  <= RST_STRICT_MASK;
            relaxed_mask_reg <= RST_RELAXED_MASK;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_SIZE:     min_size_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_AVG_SIZE:     avg_size_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_MAX_SIZE:     max_size_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_STRICT_MASK:  strict_mask_reg  <= cfg_wdata;
                REG_RELAXED_MASK: relaxed_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fp_reg      <= '0;
            count_reg   <= '0;
            offset_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= cut;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            fp_reg     <= fp_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_eod_reg  <= s_end_of_data;
        end
        if (advance && cut) begin
            out_end_reg   <= off64[END_W-1:0];
            out_len_reg   <= len[SIZE_W-1:0];
            out_cause_reg <= cause;
        end
    end

    // after the last byte of the data the chunk state and the offset restart
    a_eod_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_eod_reg) |=> (offset_reg == '0 && count_reg == '0 && fp_reg == '0))
        else $error("state not cleared after end of data");

    // a byte that does not cut grows the chunk by one
    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cut) |=> (CMP_W'(count_reg) == $past(len)))
        else $error("chunk length did not advance");

    // the input register only waits behind a held output record
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |-> (out_vld_reg && !m_ready))
        else $error("input register stalled without output backpressure");

endmodule

### dv/fastcdc_chunk_boundary_core_tb.sv
// ---------------------------------------------------------------------------
// fastcdc_chunk_boundary_core_tb: self-checking bench for the chunk boundary core
// A directed table (reset values, forced cuts, end of data, degenerate sizes
// and masks) followed by randomized byte streams under several size and mask
// settings. Each accepted byte runs through a Gear fingerprint cut predictor;
// every boundary record is compared with the oldest expected chunk.
// ---------------------------------------------------------------------------
module fastcdc_chunk_boundary_core_tb;
    import fcdc_pkg::*;

    localparam int          CHUNK_CAP  = 1048576;
    localparam logic [47:0] OFFSET_TOP = 48'hFFFF_FFFF_FFFF;
    localparam int          HOLD_LEN   = 300;
    localparam int          DRAIN_MAX  = 5000;

    typedef struct {
        logic [END_W-1:0]   chunk_end;
        logic [SIZE_W-1:0]  chunk_length;
        logic [CAUSE_W-1:0] cut_cause;
    } cut_rec_t;

    typedef struct {
        bit                is_cfg;
        logic [ADDR_W-1:0] reg_idx;
        logic [MASK_W-1:0] reg_val;
        logic [7:0]        byte_val;
        bit                last;
        bit                typed;
        cut_rec_t          want;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [MASK_W-1:0]  cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_byte_value;
    logic               s_end_of_data;
    logic               m_valid;
    logic               m_ready;
    logic [END_W-1:0]   m_chunk_end;
    logic [SIZE_W-1:0]  m_chunk_length;
    logic [CAUSE_W-1:0] m_cut_cause;

    // predictor state and its copy of the registers
    logic [47:0] gear_tab [256];
    logic [47:0] fp;
    logic [63:0] run_len;
    logic [47:0] stream_pos;
    logic [20:0] lim_min, lim_avg, lim_max;
    logic [47:0] strict_m, relaxed_m;

    cut_rec_t  pending_cuts [$];
    stim_row_t dir_rows [$];
    int        fault_count = 0;
    int        send_idle   = 25;
    int        recv_idle   = 56;
    bit        hold_req    = 1'b0;

    fastcdc_chunk_boundary_core #(
        .MAX_CHUNK_BYTES(CHUNK_CAP),
        .OFFSET_BITS    (48),
        .WINDOW_BITS    (48)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_value  (s_byte_value),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chunk_end   (m_chunk_end),
        .m_chunk_length(m_chunk_length),
        .m_cut_cause   (m_cut_cause)
    );

    always #10 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Gear fingerprint step for one byte; returns 1 when the byte closes a chunk
    function automatic bit cut_predict(input logic [7:0] b, input bit last,
                                       output cut_rec_t rec);
        logic [63:0] len;
        logic [63:0] top;
        logic [47:0] msk;
        len = run_len + 1;
        top = (lim_max < CHUNK_CAP) ? 64'(lim_max) : 64'(CHUNK_CAP);
        if (stream_pos < OFFSET_TOP)
            stream_pos = stream_pos + 1;
        rec.chunk_end    = stream_pos;
        rec.chunk_length = len[20:0];
        rec.cut_cause    = CAUSE_MATCH;
        if (last) begin
            rec.cut_cause = CAUSE_EOD;
            fp         = '0;
            run_len    = '0;
            stream_pos = '0;
            return 1'b1;
        end
        if (len >= top) begin
            rec.cut_cause = CAUSE_MAX;
            fp      = '0;
            run_len = '0;
            return 1'b1;
        end
        if (len >= lim_min) begin
            msk = (len < lim_avg) ? strict_m : relaxed_m;
            fp  = (fp << 1) + gear_tab[b];
            if ((fp & msk) == '0) begin
                fp      = '0;
                run_len = '0;
                return 1'b1;
            end
        end
        run_len = len;
        return 1'b0;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [47:0] sparse_mask(input int bits);
        logic [47:0] m;
        m = '0;
        repeat (bits) m[$urandom_range(0, 47)] = 1'b1;
        return m;
    endfunction

    function automatic void add_cfg(input logic [ADDR_W-1:0] idx, input logic [47:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input bit last);
        stim_row_t r;
        r = '{default: '0};
        r.byte_val = b;
        r.last     = last;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cut(input logic [7:0] b, input bit last, input int e,
                                    input int l, input logic [CAUSE_W-1:0] c);
        stim_row_t r;
        r = '{default: '0};
        r.byte_val           = b;
        r.last               = last;
        r.typed              = 1'b1;
        r.want.chunk_end     = 48'(e);
        r.want.chunk_length  = 21'(l);
        r.want.cut_cause     = c;
        dir_rows.push_back(r);
    endfunction

    // all tasks start and end on a falling edge
    task automatic cfg_write(input logic [ADDR_W-1:0] idx, input logic [47:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_MIN_SIZE:     lim_min   = val[20:0];
            REG_AVG_SIZE:     lim_avg   = val[20:0];
            REG_MAX_SIZE:     lim_max   = val[20:0];
            REG_STRICT_MASK:  strict_m  = val;
            REG_RELAXED_MASK: relaxed_m = val;
            default: ;
        endcase
    endtask

    task automatic set_sizes(input logic [20:0] mn, input logic [20:0] av,
                             input logic [20:0] mx, input logic [47:0] sm,
                             input logic [47:0] rm);
        cfg_write(REG_MIN_SIZE, 48'(mn));
        cfg_write(REG_AVG_SIZE, 48'(av));
        cfg_write(REG_MAX_SIZE, 48'(mx));
        cfg_write(REG_STRICT_MASK, sm);
        cfg_write(REG_RELAXED_MASK, rm);
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        while (pending_cuts.size() > 0 && n < DRAIN_MAX) begin
            @(posedge aclk);
            n++;
        end
        if (pending_cuts.size() > 0) begin
            $error("%0d chunk records never arrived", pending_cuts.size());
            fault_count++;
            pending_cuts.delete();
        end
        // bytes with no cut may still be in the pipe
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drive_byte(input logic [7:0] b, input bit last, input bit typed,
                              input cut_rec_t want);
        cut_rec_t rec;
        bit       cut;
        // idle cycles are drawn singly with send_idle percent odds, so send_idle is the idle share of cycles
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_byte_value  = b;
        s_end_of_data = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cut = cut_predict(b, last, rec);
        if (typed)
            pending_cuts.push_back(want);
        else if (cut)
            pending_cuts.push_back(rec);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic run_phase(input int n, input int eod_odds, input bit hold);
        cut_rec_t none;
        none = '{default: '0};
        if (hold)
            hold_req = 1'b1;
        for (int i = 0; i < n; i++) begin
            drive_byte(8'($urandom_range(0, 255)), ($urandom_range(1, eod_odds) == 1),
                       1'b0, none);
        end
        wait_drain();
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
            end
            m_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin : check_cuts
        cut_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cuts.size() == 0) begin
                $error("unexpected chunk record: end %0d length %0d cause %0d",
                       m_chunk_end, m_chunk_length, m_cut_cause);
                fault_count++;
            end else begin
                want = pending_cuts.pop_front();
                if (m_chunk_end !== want.chunk_end) begin
                    $error("chunk_end: expected %0d, got %0d", want.chunk_end, m_chunk_end);
                    fault_count++;
                end
                if (m_chunk_length !== want.chunk_length) begin
                    $error("chunk_length: expected %0d, got %0d",
                           want.chunk_length, m_chunk_length);
                    fault_count++;
                end
                if (m_cut_cause !== want.cut_cause) begin
                    $error("cut_cause: expected %0d, got %0d", want.cut_cause, m_cut_cause);
                    fault_count++;
                end
            end
        end
    end

    initial begin : main
        logic [63:0] x;
        stim_row_t   r;

        x = GEAR_SEED;
        for (int k = 0; k < 256; k++) begin
            x = x ^ (x << GEAR_SH_A);
            x = x ^ (x >> GEAR_SH_B);
            x = x ^ (x << GEAR_SH_C);
            gear_tab[k] = x[47:0];
        end
        fp         = '0;
        run_len    = '0;
        stream_pos = '0;
        lim_min    = 21'd2048;
        lim_avg    = 21'd8192;
        lim_max    = 21'd65536;
        strict_m   = 48'hd9f0_0353_0000;
        relaxed_m  = 48'hd900_0353_0000;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_byte_value  = '0;
        s_end_of_data = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values: only end of data can close a chunk this early
        add_byte(8'h00, 1'b0);
        add_cut(8'hFF, 1'b1, 2, 2, CAUSE_EOD);
        add_cut(8'h5A, 1'b1, 1, 1, CAUSE_EOD);
        // zero max size: one byte per chunk, end of data still wins
        add_cfg(REG_MAX_SIZE, 48'd0);
        add_cut(8'h00, 1'b0, 1, 1, CAUSE_MAX);
        add_cut(8'hFF, 1'b0, 2, 1, CAUSE_MAX);
        add_cut(8'h80, 1'b1, 3, 1, CAUSE_EOD);
        // max below min: masks never tested
        add_cfg(REG_MAX_SIZE, 48'd3);
        add_cfg(REG_MIN_SIZE, 48'h10_0000);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_cut(8'h03, 1'b0, 3, 3, CAUSE_MAX);
        add_byte(8'h04, 1'b0);
        add_cut(8'h05, 1'b1, 5, 2, CAUSE_EOD);
        // empty masks: every tested byte matches
        add_cfg(REG_MIN_SIZE, 48'd1);
        add_cfg(REG_AVG_SIZE, 48'd1);
        add_cfg(REG_MAX_SIZE, 48'h10_0000);
        add_cfg(REG_STRICT_MASK, 48'd0);
        add_cfg(REG_RELAXED_MASK, 48'd0);
        add_cut(8'h00, 1'b0, 1, 1, CAUSE_MATCH);
        add_cut(8'hFF, 1'b0, 2, 1, CAUSE_MATCH);
        add_cut(8'h7F, 1'b1, 3, 1, CAUSE_EOD);
        // full masks, avg above max: strict mask only
        add_cfg(REG_STRICT_MASK, 48'hFFFF_FFFF_FFFF);
        add_cfg(REG_RELAXED_MASK, 48'hFFFF_FFFF_FFFF);
        add_cfg(REG_AVG_SIZE, 48'h1F_FFFF);
        add_cfg(REG_MAX_SIZE, 48'd6);
        add_byte(8'h00, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h10, 1'b1);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.is_cfg) begin
                wait_drain();
                cfg_write(r.reg_idx, r.reg_val);
            end else begin
                drive_byte(r.byte_val, r.last, r.typed, r.want);
            end
        end
        wait_drain();

        // sender light, receiver heavy; long output stall in the first phase
        set_sizes(21'd1, 21'd16, 21'd48, sparse_mask(4), sparse_mask(2));
        run_phase(110, 40, 1'b1);
        set_sizes(21'($urandom_range(1, 8)), 21'($urandom_range(1, 40)),
                  21'($urandom_range(8, 64)), sparse_mask(3), sparse_mask(1));
        run_phase(110, 30, 1'b0);

        send_idle = 56;
        recv_idle = 25;
        set_sizes(21'd4, 21'h1F_FFFF, 21'd40, sparse_mask(5), 48'hFFFF_FFFF_FFFF);
        run_phase(110, 50, 1'b0);
        set_sizes(21'h10_0000, 21'($urandom_range(1, 64)), 21'd20, rand48(),
                  sparse_mask(2));
        run_phase(100, 30, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        set_sizes(21'd1, 21'd8, 21'h10_0000, sparse_mask(2), rand48());
        run_phase(110, 25, 1'b0);
        set_sizes(21'($urandom_range(1, 16)), 21'($urandom_range(1, 32)),
                  21'($urandom_range(1, 100)), sparse_mask(3), sparse_mask(2));
        run_phase(100, 40, 1'b0);

        repeat (10) @(posedge aclk);
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### fastcdc_chunk_boundary_core.f
rtl/fcdc_pkg.sv
rtl/fastcdc_chunk_boundary_core.sv
dv/fastcdc_chunk_boundary_core_tb.sv
